// ===== sv/cbez_pkg.sv =====
// Shared constants, types and codes for the cubic Bezier evaluator.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package cbez_pkg;

  // Coordinate and parameter formats
  localparam int CW    = 16;          // coordinate width, 8 fraction bits
  localparam int F     = 16;          // fraction bits of t
  localparam int TW    = F + 1;       // width of t, one integer bit
  localparam int OW    = 24;          // result width
  localparam int NAXES = 3;
  localparam int NPTS  = 4;
  localparam int REGW  = NAXES * CW;  // packed control point register
  localparam int IDXW  = 2;           // register index width

  // Datapath widths
  localparam int KW   = CW + 6;             // holds 6d, the largest coefficient
  localparam int A1W  = KW + TW + 1;        // k3*t + k2
  localparam int L1   = A1W / 2;            // low slice of first partial product split
  localparam int PLW  = L1 + TW;
  localparam int PHW  = A1W - L1 + TW + 1;
  localparam int A2W  = A1W + TW + 1;       // (k3*t + k2)*t + k1
  localparam int L2   = A2W / 2;
  localparam int QLW  = L2 + TW;
  localparam int QHW  = A2W - L2 + TW + 1;
  localparam int RW   = 3 * F + OW;         // final sum, kept modulo 2^RW
  localparam int NST  = 7;                  // register stages

  localparam logic [TW-1:0] PONE = {1'b1, {F{1'b0}}};

  // Register indexes
  localparam logic [IDXW-1:0] REG_POINT_ZERO  = 2'd0;
  localparam logic [IDXW-1:0] REG_POINT_ONE   = 2'd1;
  localparam logic [IDXW-1:0] REG_POINT_TWO   = 2'd2;
  localparam logic [IDXW-1:0] REG_POINT_THREE = 2'd3;

  typedef enum logic [1:0] {
    OP_POSITION = 2'd0,
    OP_VELOCITY = 2'd1,
    OP_ACCEL    = 2'd2,
    OP_JERK     = 2'd3
  } op_t;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [KW-1:0]  kw_t;
  typedef logic signed [A1W-1:0] acc1_t;
  typedef logic signed [A2W-1:0] acc2_t;
  typedef logic signed [RW-1:0]  fin_t;

  // Power basis coefficients of one axis, with the scaled copies the
  // derivatives need
  typedef struct packed {
    kw_t a;
    kw_t b;
    kw_t c;
    kw_t c2;
    kw_t d;
    kw_t d3;
    kw_t d6;
  } coef_t;

  typedef struct packed {
    op_t           operation;
    logic [TW-1:0] curve_param;
  } in_item_t;

  typedef struct packed {
    logic signed [OW-1:0] out_x;
    logic signed [OW-1:0] out_y;
    logic signed [OW-1:0] out_z;
  } out_item_t;

endpackage

// ===== sv/cbez_cfg.sv =====
// Control point registers and power basis coefficient formation.
// Depends on cbez_pkg.
`timescale 1ns / 1ps

module cbez_cfg (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_we,
  input  logic [cbez_pkg::IDXW-1:0]                   cfg_index,
  input  logic [cbez_pkg::REGW-1:0]                   cfg_data,
  output cbez_pkg::coef_t [cbez_pkg::NAXES-1:0]       coef
);

  logic [cbez_pkg::REGW-1:0] points [cbez_pkg::NPTS];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbez_pkg::NPTS; i++) begin
        points[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        cbez_pkg::REG_POINT_ZERO:  points[0] <= cfg_data;
        cbez_pkg::REG_POINT_ONE:   points[1] <= cfg_data;
        cbez_pkg::REG_POINT_TWO:   points[2] <= cfg_data;
        cbez_pkg::REG_POINT_THREE: points[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // a = P0, b = 3(P1-P0), c = 3(P0-2P1+P2), d = -P0+3P1-3P2+P3
  for (genvar ax = 0; ax < cbez_pkg::NAXES; ax++) begin : g_axis
    cbez_pkg::coord_t q0, q1, q2, q3;
    cbez_pkg::kw_t    e0, e1, e2, e3;
    cbez_pkg::kw_t    diff, sec, mid, dval, cval;

    assign q0 = points[0][ax*cbez_pkg::CW +: cbez_pkg::CW];
    assign q1 = points[1][ax*cbez_pkg::CW +: cbez_pkg::CW];
    assign q2 = points[2][ax*cbez_pkg::CW +: cbez_pkg::CW];
    assign q3 = points[3][ax*cbez_pkg::CW +: cbez_pkg::CW];

    assign e0 = cbez_pkg::kw_t'(q0);
    assign e1 = cbez_pkg::kw_t'(q1);
    assign e2 = cbez_pkg::kw_t'(q2);
    assign e3 = cbez_pkg::kw_t'(q3);

    assign diff = e1 - e0;
    assign sec  = e0 - (e1 <<< 1) + e2;
    assign mid  = e1 - e2;
    assign cval = sec + (sec <<< 1);
    assign dval = e3 - e0 + mid + (mid <<< 1);

    assign coef[ax].a  = e0;
    assign coef[ax].b  = diff + (diff <<< 1);
    assign coef[ax].c  = cval;
    assign coef[ax].c2 = cval <<< 1;
    assign coef[ax].d  = dval;
    assign coef[ax].d3 = dval + (dval <<< 1);
    assign coef[ax].d6 = (dval + (dval <<< 1)) <<< 1;
  end

endmodule

// ===== sv/cbez_ctrl.sv =====
// Valid tracking and per-stage load enables for the evaluation pipeline.
// Depends on cbez_pkg.
`timescale 1ns / 1ps

module cbez_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [cbez_pkg::NST-1:0] en
);

  logic [cbez_pkg::NST-1:0] valid;
  logic [cbez_pkg::NST-1:0] valid_next;
  logic [cbez_pkg::NST-1:0] stage_ready;
  logic                     in_fire;
  logic                     out_fire;

  // A stage can take an item when empty or when its own item moves on
  assign stage_ready[cbez_pkg::NST-1] = !valid[cbez_pkg::NST-1] || out_ready;
  for (genvar i = 0; i < cbez_pkg::NST - 1; i++) begin : g_rdy
    assign stage_ready[i] = !valid[i] || stage_ready[i+1];
  end

  assign en        = {valid[cbez_pkg::NST-2:0], in_valid} & stage_ready;
  assign in_ready  = stage_ready[0];
  assign out_valid = valid[cbez_pkg::NST-1];
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // Stalled stages keep their item; ready stages take from upstream
  assign valid_next = (valid & ~stage_ready)
                    | ({valid[cbez_pkg::NST-2:0], in_valid} & stage_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

`ifndef ASSERT_OFF
  // Items in flight change only by accepted inputs and delivered results
  a_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(valid) == $countones($past(valid))
                     + int'($past(in_fire)) - int'($past(out_fire))))
    else $error("pipeline occupancy does not match transactions");

  // Input is refused only when every stage is full and the output stalls
  a_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ((&valid) && !out_ready))
    else $error("input refused with room in the pipeline");

  // A stalled stage still holds its item in the next cycle
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((valid & $past(valid & ~stage_ready))
                     == $past(valid & ~stage_ready)))
    else $error("stalled stage dropped its item");
`endif

endmodule

// ===== sv/cbez_lane.sv =====
// One axis of the evaluator: Horner evaluation of a cubic in t over
// seven register stages, wide products split into two narrower halves.
// Depends on cbez_pkg.
`timescale 1ns / 1ps

module cbez_lane (
  input  logic                            clk,
  input  logic [cbez_pkg::NST-1:0]        en,
  input  cbez_pkg::op_t                   operation,
  input  logic [cbez_pkg::TW-1:0]         curve_param,
  input  cbez_pkg::coef_t                 coef,
  output logic signed [cbez_pkg::OW-1:0]  res
);

  cbez_pkg::kw_t k3_sel, k2_sel, k1_sel, k0_sel;
  logic [cbez_pkg::TW-1:0] t_sel;

  // stage registers
  cbez_pkg::kw_t k3_s1, k2_s1, k1_s1, k0_s1;
  cbez_pkg::kw_t k2_s2, k1_s2, k0_s2;
  cbez_pkg::kw_t k1_s3, k0_s3;
  cbez_pkg::kw_t k1_s4, k0_s4;
  cbez_pkg::kw_t k0_s5, k0_s6;
  logic [cbez_pkg::TW-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;
  cbez_pkg::acc1_t m_s2, acc1_s3;
  logic [cbez_pkg::PLW-1:0] pl_s4;
  logic signed [cbez_pkg::PHW-1:0] ph_s4;
  cbez_pkg::acc2_t acc2_s5;
  logic [cbez_pkg::QLW-1:0] ql_s6;
  logic signed [cbez_pkg::QHW-1:0] qh_s6;
  cbez_pkg::fin_t fin_sum;

  // Operation select: derivatives are lower-degree cubics padded with zeros
  always_comb begin
    k3_sel = '0;
    k2_sel = '0;
    k1_sel = '0;
    k0_sel = '0;
    case (operation)
      cbez_pkg::OP_POSITION: begin
        k3_sel = coef.d;
        k2_sel = coef.c;
        k1_sel = coef.b;
        k0_sel = coef.a;
      end
      cbez_pkg::OP_VELOCITY: begin
        k2_sel = coef.d3;
        k1_sel = coef.c2;
        k0_sel = coef.b;
      end
      cbez_pkg::OP_ACCEL: begin
        k1_sel = coef.d6;
        k0_sel = coef.c2;
      end
      cbez_pkg::OP_JERK: begin
        k0_sel = coef.d6;
      end
      default: ;
    endcase
  end

  // t above one clamps to exactly one
  assign t_sel = (curve_param > cbez_pkg::PONE) ? cbez_pkg::PONE : curve_param;

  // Final sum modulo 2^RW; the top OW bits are the floored result
  assign fin_sum = (cbez_pkg::fin_t'(qh_s6) << cbez_pkg::L2)
                 + cbez_pkg::fin_t'(ql_s6)
                 + (cbez_pkg::fin_t'(k0_s6) << (3 * cbez_pkg::F));

  // Stage 1: coefficients and t
  always_ff @(posedge clk) begin
    if (en[0]) begin
      k3_s1 <= k3_sel;
      k2_s1 <= k2_sel;
      k1_s1 <= k1_sel;
      k0_s1 <= k0_sel;
      t_s1  <= t_sel;
    end
  end

  // Stage 2: k3 * t
  always_ff @(posedge clk) begin
    if (en[1]) begin
      m_s2  <= cbez_pkg::acc1_t'(k3_s1)
             * cbez_pkg::acc1_t'($signed({1'b0, t_s1}));
      k2_s2 <= k2_s1;
      k1_s2 <= k1_s1;
      k0_s2 <= k0_s1;
      t_s2  <= t_s1;
    end
  end

  // Stage 3: + k2, first Horner step done
  always_ff @(posedge clk) begin
    if (en[2]) begin
      acc1_s3 <= m_s2 + (cbez_pkg::acc1_t'(k2_s2) << cbez_pkg::F);
      k1_s3   <= k1_s2;
      k0_s3   <= k0_s2;
      t_s3    <= t_s2;
    end
  end

  // Stage 4: acc1 * t as two partial products
  always_ff @(posedge clk) begin
    if (en[3]) begin
      pl_s4 <= cbez_pkg::PLW'(acc1_s3[cbez_pkg::L1-1:0]) * cbez_pkg::PLW'(t_s3);
      ph_s4 <= cbez_pkg::PHW'($signed(acc1_s3[cbez_pkg::A1W-1:cbez_pkg::L1]))
             * cbez_pkg::PHW'($signed({1'b0, t_s3}));
      k1_s4 <= k1_s3;
      k0_s4 <= k0_s3;
      t_s4  <= t_s3;
    end
  end

  // Stage 5: recombine and add k1
  always_ff @(posedge clk) begin
    if (en[4]) begin
      acc2_s5 <= (cbez_pkg::acc2_t'(ph_s4) << cbez_pkg::L1)
               + cbez_pkg::acc2_t'(pl_s4)
               + (cbez_pkg::acc2_t'(k1_s4) << (2 * cbez_pkg::F));
      k0_s5   <= k0_s4;
      t_s5    <= t_s4;
    end
  end

  // Stage 6: acc2 * t as two partial products
  always_ff @(posedge clk) begin
    if (en[5]) begin
      ql_s6 <= cbez_pkg::QLW'(acc2_s5[cbez_pkg::L2-1:0]) * cbez_pkg::QLW'(t_s5);
      qh_s6 <= cbez_pkg::QHW'($signed(acc2_s5[cbez_pkg::A2W-1:cbez_pkg::L2]))
             * cbez_pkg::QHW'($signed({1'b0, t_s5}));
      k0_s6 <= k0_s5;
    end
  end

  // Stage 7: add k0 and floor by dropping the fraction bits
  always_ff @(posedge clk) begin
    if (en[6]) begin
      res <= fin_sum[cbez_pkg::RW-1:3*cbez_pkg::F];
    end
  end

endmodule

// ===== sv/cubic_bezier_evaluator_core.sv =====
// Top level of the cubic Bezier evaluator: configuration, pipeline control
// and three axis lanes. Depends on cbez_pkg, cbez_cfg, cbez_ctrl, cbez_lane.
`timescale 1ns / 1ps

// Usage
//   Configuration: cfg_we writes cfg_data into control point cfg_index
//   (0..3, x/y/z packed as signed Q7.8 in 16-bit slices). Write only while
//   no transaction is in flight.
//   Input: in_valid/in_ready carry in_data {operation, curve_param}; t is
//   unsigned Q1.16 and values above one are treated as one. Operation picks
//   position, velocity, acceleration or jerk.
//   Output: out_valid/out_ready carry out_data {out_x, out_y, out_z}, signed
//   with eight fraction bits, floored.
//   Pipeline: the first of the seven register stages loads at acceptance
//   (two multiply stages split into partial products, each followed by an
//   add stage).
//   Throughput: one transaction per cycle while the receiver takes results.
//   Stalls: a stalled output holds its result; upstream stages keep filling
//   any empty slots, and in_ready drops only when all seven stages are full.
//   Reset: rst clears the control points to zero and empties the pipeline.

module cubic_bezier_evaluator_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [cbez_pkg::IDXW-1:0] cfg_index,
  input  logic [cbez_pkg::REGW-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cbez_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cbez_pkg::out_item_t       out_data
);

  cbez_pkg::coef_t [cbez_pkg::NAXES-1:0] coef;
  logic [cbez_pkg::NST-1:0]              en;
  logic [cbez_pkg::NAXES-1:0][cbez_pkg::OW-1:0] res;

  // Control point registers and coefficients
  cbez_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Pipeline valid bits and stage enables
  cbez_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  // One lane per axis
  for (genvar ax = 0; ax < cbez_pkg::NAXES; ax++) begin : g_lane
    cbez_lane u_lane (
      .clk         (clk),
      .en          (en),
      .operation   (in_data.operation),
      .curve_param (in_data.curve_param),
      .coef        (coef[ax]),
      .res         (res[ax])
    );
  end

  assign out_data.out_x = res[0];
  assign out_data.out_y = res[1];
  assign out_data.out_z = res[2];

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for cubic_bezier_evaluator_core: curve parameters
// are streamed under random handshake gaps and each result is compared with a
// predicted position or derivative. Depends on cbez_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import cbez_pkg::*;

  typedef logic signed [127:0] wide_t;

  // One row of the directed stimulus table
  typedef struct {
    bit            reload;   // write the directed control points first
    op_t           op;
    logic [TW-1:0] t;
    bit            known;    // expected result typed in below
    int            ex;
    int            ey;
    int            ez;
  } dir_row_t;

  localparam int N_DIR      = 22;
  localparam int N_PHASES   = 10;
  localparam int PHASE_LEN  = 125;
  localparam int HOLD_LEN   = 40;

  // Directed control points, {z, y, x} per register
  localparam logic [REGW-1:0] DIR_P0 = 48'h0100_8000_7FFF;
  localparam logic [REGW-1:0] DIR_P1 = 48'h8000_7FFF_8000;
  localparam logic [REGW-1:0] DIR_P2 = 48'h7FFF_8000_7FFF;
  localparam logic [REGW-1:0] DIR_P3 = 48'hFF00_7FFF_8000;
  localparam logic [REGW-1:0] ALL_MAX  = {NAXES{16'h7FFF}};
  localparam logic [REGW-1:0] ALL_MIN  = {NAXES{16'h8000}};
  localparam logic [REGW-1:0] ALL_ONES = {REGW{1'b1}};

  dir_row_t dir_tab [N_DIR] = '{
    // after reset every control point is zero
    '{0, OP_POSITION, 17'h00000, 1, 0, 0, 0},
    '{0, OP_VELOCITY, 17'h10000, 1, 0, 0, 0},
    '{0, OP_ACCEL,    17'h1FFFF, 1, 0, 0, 0},
    '{0, OP_JERK,     17'h0AAAA, 1, 0, 0, 0},
    // curve ends sit on the first and last control points
    '{1, OP_POSITION, 17'h00000, 1, 32767, -32768, 256},
    '{0, OP_POSITION, 17'h10000, 1, -32768, 32767, -256},
    // parameter above one clamps to one
    '{0, OP_POSITION, 17'h1FFFF, 1, -32768, 32767, -256},
    '{0, OP_POSITION, 17'h10001, 1, -32768, 32767, -256},
    '{0, OP_POSITION, 17'h00001, 0, 0, 0, 0},
    '{0, OP_POSITION, 17'h08000, 0, 0, 0, 0},
    '{0, OP_POSITION, 17'h0FFFF, 0, 0, 0, 0},
    '{0, OP_VELOCITY, 17'h00000, 0, 0, 0, 0},
    '{0, OP_VELOCITY, 17'h08000, 0, 0, 0, 0},
    '{0, OP_VELOCITY, 17'h10000, 0, 0, 0, 0},
    '{0, OP_VELOCITY, 17'h15555, 0, 0, 0, 0},
    '{0, OP_ACCEL,    17'h00000, 0, 0, 0, 0},
    '{0, OP_ACCEL,    17'h05555, 0, 0, 0, 0},
    '{0, OP_ACCEL,    17'h10000, 0, 0, 0, 0},
    '{0, OP_ACCEL,    17'h1FFFF, 0, 0, 0, 0},
    // jerk ignores the parameter
    '{0, OP_JERK,     17'h00000, 0, 0, 0, 0},
    '{0, OP_JERK,     17'h1FFFF, 0, 0, 0, 0},
    '{0, OP_JERK,     17'h0AAAA, 0, 0, 0, 0}
  };

  logic                clk;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [IDXW-1:0]     cfg_index = '0;
  logic [REGW-1:0]     cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;

  // Predictor state and scoreboard
  logic [REGW-1:0]     pts_model [NPTS];
  out_item_t           curve_due_q [$];
  int                  n_err       = 0;
  int                  n_sent      = 0;
  bit                  tx_steady   = 1'b0;
  bit                  rx_steady   = 1'b0;
  bit                  rx_hold_req = 1'b0;

  cubic_bezier_evaluator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Exact power-basis evaluation per axis, floored once to the coordinate scale
  function automatic out_item_t bezier_predict(input in_item_t it);
    wide_t                t, p0, p1, p2, p3, a, b, c, d, acc;
    logic [TW-1:0]        tp;
    logic signed [OW-1:0] lane [NAXES];
    out_item_t            r;
    int                   ax;
    tp = (it.curve_param > PONE) ? PONE : it.curve_param;
    t  = wide_t'(tp);
    for (ax = 0; ax < NAXES; ax++) begin
      p0 = wide_t'(coord_t'(pts_model[REG_POINT_ZERO][ax*CW +: CW]));
      p1 = wide_t'(coord_t'(pts_model[REG_POINT_ONE][ax*CW +: CW]));
      p2 = wide_t'(coord_t'(pts_model[REG_POINT_TWO][ax*CW +: CW]));
      p3 = wide_t'(coord_t'(pts_model[REG_POINT_THREE][ax*CW +: CW]));
      a  = p0;
      b  = 3 * (p1 - p0);
      c  = 3 * (p0 - 2 * p1 + p2);
      d  = -p0 + 3 * p1 - 3 * p2 + p3;
      case (it.operation)
        OP_POSITION: acc = ((a <<< (3*F)) + ((b * t) <<< (2*F)) + ((c * t * t) <<< F)
                            + d * t * t * t) >>> (3*F);
        OP_VELOCITY: acc = ((b <<< (2*F)) + ((2 * c * t) <<< F) + 3 * d * t * t) >>> (2*F);
        OP_ACCEL:    acc = (((2 * c) <<< F) + 6 * d * t) >>> F;
        default:     acc = 6 * d;
      endcase
      lane[ax] = acc[OW-1:0];
    end
    r.out_x = lane[0];
    r.out_y = lane[1];
    r.out_z = lane[2];
    return r;
  endfunction

  function automatic int pick_gap(input bit steady);
    return steady ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Mostly in-range parameters, with endpoints and the odd clamped value
  function automatic in_item_t rand_curve_item();
    in_item_t    it;
    int unsigned sel;
    it.operation = op_t'($urandom_range(0, 3));
    sel = $urandom_range(0, 15);
    case (sel)
      0:       it.curve_param = '0;
      1:       it.curve_param = PONE;
      2, 3:    it.curve_param = TW'($urandom);
      default: it.curve_param = TW'($urandom_range(0, PONE));
    endcase
    return it;
  endfunction

  function automatic logic [REGW-1:0] rand_point();
    return REGW'({$urandom, $urandom});
  endfunction

  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [REGW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    pts_model[idx] = val;
  endtask

  task automatic load_points(input logic [REGW-1:0] v0, v1, v2, v3);
    write_reg(REG_POINT_ZERO, v0);
    write_reg(REG_POINT_ONE, v1);
    write_reg(REG_POINT_TWO, v2);
    write_reg(REG_POINT_THREE, v3);
    cfg_we <= 1'b0;
  endtask

  // Idle the input until every expected result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (curve_due_q.size() != 0);
  endtask

  // One input transaction; valid is held until the handshake
  task automatic send_item(input in_item_t it, input bit known, input out_item_t known_res);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    curve_due_q = {curve_due_q, (known ? known_res : bezier_predict(it))};
    n_sent++;
  endtask

  task automatic check_field(input string name, input logic signed [OW-1:0] want,
                             input logic signed [OW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  // Receiver: random ready gaps, one long hold-off on request
  initial begin : rx_proc
    int gap;
    forever begin
      gap = pick_gap(rx_steady);
      if (rx_hold_req) begin
        gap = HOLD_LEN;
        rx_hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Result checker
  always @(posedge clk) begin : res_chk
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (curve_due_q.size() == 0) begin
        $error("result with no transaction outstanding: x=%0d y=%0d z=%0d",
               out_data.out_x, out_data.out_y, out_data.out_z);
        n_err++;
      end else begin
        want = curve_due_q.pop_front();
        check_field("out_x", want.out_x, out_data.out_x);
        check_field("out_y", want.out_y, out_data.out_y);
        check_field("out_z", want.out_z, out_data.out_z);
      end
    end
  end

  // Stimulus
  initial begin : stim
    out_item_t want;
    int        i, ph, k;
    for (i = 0; i < NPTS; i++) pts_model[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].reload) begin
        wait_drained();
        load_points(DIR_P0, DIR_P1, DIR_P2, DIR_P3);
      end
      want.out_x = OW'(dir_tab[i].ex);
      want.out_y = OW'(dir_tab[i].ey);
      want.out_z = OW'(dir_tab[i].ez);
      send_item('{operation: dir_tab[i].op, curve_param: dir_tab[i].t},
                dir_tab[i].known, want);
    end

    // random phases, each with its own control points
    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        1:       load_points(ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX);
        2:       load_points(ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN);
        3:       load_points(ALL_MIN, ALL_MAX, ALL_MIN, ALL_MAX);   // largest |d|
        4:       load_points(ALL_MAX, ALL_MIN, ALL_MAX, ALL_MIN);
        5:       load_points(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        default: load_points(rand_point(), rand_point(), rand_point(), rand_point());
      endcase
      // back-pressure: receiver stalls while the sender streams
      if (ph == 3) rx_hold_req = 1'b1;
      for (k = 0; k < PHASE_LEN; k++) begin
        tx_steady = (ph == 3 && k < 60) || ((n_sent / 32) % 3 == 1);
        rx_steady = ((n_sent / 45) % 2 == 1);
        if (ph == 6 && k == 60) wait_drained();
        send_item(rand_curve_item(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (NST + 4) @(posedge clk);
    if (curve_due_q.size() != 0) begin
      $error("%0d results never arrived", curve_due_q.size());
      n_err++;
    end
    if (n_err == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
